### sv/aff2d_pkg.sv
// Package for the 2x3 affine matrix unit: request/result structs, codes, widths.
// Used by every module of the block; depends on nothing.
package aff2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_INV  = 2'd2;
  localparam logic [1:0] OP_MAP  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] coef_00;
    logic signed [31:0] coef_01;
    logic signed [31:0] coef_02;
    logic signed [31:0] coef_10;
    logic signed [31:0] coef_11;
    logic signed [31:0] coef_12;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_00;
    logic signed [31:0] out_01;
    logic signed [31:0] out_02;
    logic signed [31:0] out_10;
    logic signed [31:0] out_11;
    logic signed [31:0] out_12;
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic [1:0]         status;
  } res_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [63:0] mag;
    logic [5:0]  shift;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        ovf;
    logic [63:0] quo;
    logic        round_up;
  } div_sts_t;

endpackage

### sv/affine_2d_transform_unit.sv
// Top level of the 2x3 affine matrix unit: sequencer, shared multiplier, matrix store.
// Depends on aff2d_pkg and aff2d_div.
//
// Holds one signed Q16.16 2x3 matrix, identity after reset. Each request loads,
// right-multiplies, inverts or maps a point and returns one result with the
// matrix after the operation, the mapped point (zero unless mapping) and a
// status. One request is in the unit at a time; ready drops from acceptance
// until the result is taken. A single 32x32 multiplier is shared over all
// products, one product a cycle. Invert forms the products and the determinant,
// checks the determinant, then runs six divisions in the shared restoring
// divider and latches the result; a refused or overflowing inverse ends sooner.
// The result sits in an output register until taken.
module affine_2d_transform_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  aff2d_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output aff2d_pkg::res_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic signed [31:0] ONE = 32'sd1 <<< aff2d_pkg::FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (aff2d_pkg::FRAC_BITS - 1);

  logic [2:0]         state;
  logic [3:0]         step;
  logic [15:0]        min_det;
  logic signed [31:0] m [6];
  logic signed [31:0] r [6];
  aff2d_pkg::req_t    req;
  aff2d_pkg::res_t    res;
  logic               ov;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               det_neg;
  logic [63:0]        det;
  logic signed [63:0] nums [2];
  logic [2:0]         ent;
  aff2d_pkg::div_cmd_t dcmd;
  aff2d_pkg::div_sts_t dsts;
  logic signed [65:0] sum_x;
  logic signed [49:0] rnd;
  logic signed [31:0] sat_v;
  logic               sat_o;
  logic [63:0]        e_mag;
  logic               e_neg;
  logic [5:0]         e_shift;
  logic [63:0]        q_r;
  logic               q_bad;
  logic signed [31:0] q_val;

  // multiplier operand schedule: steps 0..11 for multiply, 0..3 for map, 0..5 for inverse, in pairs of products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (req.operation == aff2d_pkg::OP_MAP) begin
      case (step)
        4'd0: begin mul_a = m[0]; mul_b = req.point_x; end
        4'd1: begin mul_a = m[1]; mul_b = req.point_y; end
        4'd2: begin mul_a = m[3]; mul_b = req.point_x; end
        default: begin mul_a = m[4]; mul_b = req.point_y; end
      endcase
    end else if (req.operation == aff2d_pkg::OP_MUL) begin
      case (step)
        4'd0:  begin mul_a = m[0]; mul_b = req.coef_00; end
        4'd1:  begin mul_a = m[1]; mul_b = req.coef_10; end
        4'd2:  begin mul_a = m[0]; mul_b = req.coef_01; end
        4'd3:  begin mul_a = m[1]; mul_b = req.coef_11; end
        4'd4:  begin mul_a = m[0]; mul_b = req.coef_02; end
        4'd5:  begin mul_a = m[1]; mul_b = req.coef_12; end
        4'd6:  begin mul_a = m[3]; mul_b = req.coef_00; end
        4'd7:  begin mul_a = m[4]; mul_b = req.coef_10; end
        4'd8:  begin mul_a = m[3]; mul_b = req.coef_01; end
        4'd9:  begin mul_a = m[4]; mul_b = req.coef_11; end
        4'd10: begin mul_a = m[3]; mul_b = req.coef_02; end
        default: begin mul_a = m[4]; mul_b = req.coef_12; end
      endcase
    end else begin
      // inverse: det = m0*m4 - m1*m3, n02 = m1*m5 - m4*m2, n12 = m3*m2 - m0*m5
      case (step)
        4'd0: begin mul_a = m[0]; mul_b = m[4]; end
        4'd1: begin mul_a = m[1]; mul_b = m[3]; end
        4'd2: begin mul_a = m[1]; mul_b = m[5]; end
        4'd3: begin mul_a = m[4]; mul_b = m[2]; end
        4'd4: begin mul_a = m[3]; mul_b = m[2]; end
        default: begin mul_a = m[0]; mul_b = m[5]; end
      endcase
    end
  end

  // one term: sum of two products, plus translation where the term has one, rounded half up and saturated;
  // the rounding is floor((p1+p2+half)/2^F)
  always_comb begin
    logic signed [31:0] t;
    t = '0;
    if (req.operation == aff2d_pkg::OP_MAP) begin
      t = (step == 4'd2) ? m[2] : m[5];
    end else if (step == 4'd6) begin
      t = m[2];
    end else if (step == 4'd12) begin
      t = m[5];
    end
    sum_x = 66'(acc) + 66'(prod) + 66'(HALF);
    rnd   = 50'(sum_x >>> aff2d_pkg::FRAC_BITS) + 50'(t);
    sat_o = (rnd > 50'sd2147483647) || (rnd < -50'sd2147483648);
    if (rnd > 50'sd2147483647) sat_v = 32'sh7fffffff;
    else if (rnd < -50'sd2147483648) sat_v = 32'sh80000000;
    else sat_v = rnd[31:0];
  end

  // divider operand for inverse entry ent
  always_comb begin
    logic signed [31:0] v;
    v       = '0;
    e_shift = 6'(2 * aff2d_pkg::FRAC_BITS);
    e_mag   = '0;
    e_neg   = 1'b0;
    case (ent)
      3'd0: begin v = m[4]; e_neg = (m[4] < 0) != det_neg; end
      3'd1: begin v = m[1]; e_neg = (m[1] >= 0) != det_neg; end
      3'd3: begin v = m[3]; e_neg = (m[3] >= 0) != det_neg; end
      3'd4: begin v = m[0]; e_neg = (m[0] < 0) != det_neg; end
      default: v = '0;
    endcase
    if (ent == 3'd2 || ent == 3'd5) begin
      e_shift = 6'(aff2d_pkg::FRAC_BITS);
      e_mag   = nums[ent == 3'd5][63] ? 64'(-nums[ent == 3'd5]) : 64'(nums[ent == 3'd5]);
      e_neg   = nums[ent == 3'd5][63] != det_neg;
    end else begin
      e_mag = v[31] ? 64'(-64'(v)) : 64'(64'(v));
    end
  end

  always_comb begin
    q_r   = dsts.quo + {63'd0, dsts.round_up};
    q_bad = dsts.ovf || (dsts.quo > 64'h80000000) ||
            (e_neg ? (q_r > 64'h80000000) : (q_r > 64'h7fffffff));
    q_val = e_neg ? 32'(-q_r[31:0]) : q_r[31:0];
  end

  assign dcmd.start = (state == S_DIV);
  assign dcmd.mag   = e_mag;
  assign dcmd.shift = e_shift;

  aff2d_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (dcmd),
    .det (det),
    .sts (dsts)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      min_det <= 16'd1;
      step    <= '0;
      ent     <= '0;
      m[0] <= ONE; m[1] <= '0; m[2] <= '0;
      m[3] <= '0;  m[4] <= ONE; m[5] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) min_det <= cfg_data;
          if (in_valid) begin
            req   <= in_data;
            step  <= '0;
            ov    <= 1'b0;
            acc   <= '0;
            res.mapped_x <= '0;
            res.mapped_y <= '0;
            res.status   <= aff2d_pkg::ST_OK;
            if (in_data.operation == aff2d_pkg::OP_LOAD) begin
              m[0] <= in_data.coef_00; m[1] <= in_data.coef_01;
              m[2] <= in_data.coef_02; m[3] <= in_data.coef_10;
              m[4] <= in_data.coef_11; m[5] <= in_data.coef_12;
              state <= S_DONE;
            end else begin
              state <= S_PROD;
            end
          end
        end
        // prod holds product of step-1; pair products into terms
        S_PROD: begin
          step <= step + 4'd1;
          if (step != 4'd0) begin
            if (req.operation == aff2d_pkg::OP_INV) begin
              if (step[0]) acc <= prod;
              else if (step == 4'd2) begin
                det_neg <= acc < prod;
                det     <= (acc < prod) ? 64'(prod - acc) : 64'(acc - prod);
              end else nums[step == 4'd6] <= acc - prod;
              if (step == 4'd6) state <= S_DET;
            end else if (step[0]) begin
              acc <= prod;
            end else begin
              acc <= '0;
              ov  <= ov | sat_o;
              if (req.operation == aff2d_pkg::OP_MAP) begin
                if (step == 4'd2) res.mapped_x <= sat_v;
                else begin
                  res.mapped_y <= sat_v;
                  res.status <= (ov | sat_o) ? aff2d_pkg::ST_OVERFLOW : aff2d_pkg::ST_OK;
                  state <= S_DONE;
                end
              end else begin
                r[3'(step[3:1] - 3'd1)] <= sat_v;
                if (step == 4'd12) begin
                  m[0] <= r[0]; m[1] <= r[1]; m[2] <= r[2];
                  m[3] <= r[3]; m[4] <= r[4]; m[5] <= sat_v;
                  res.status <= (ov | sat_o) ? aff2d_pkg::ST_OVERFLOW : aff2d_pkg::ST_OK;
                  state <= S_DONE;
                end
              end
            end
          end
        end
        S_DET: begin
          ent <= '0;
          if (det == 64'd0 || det < 64'(min_det)) begin
            res.status <= aff2d_pkg::ST_SINGULAR;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (dsts.done) begin
            if (q_bad) begin
              res.status <= aff2d_pkg::ST_OVERFLOW;
              state <= S_DONE;
            end else begin
              r[ent] <= q_val;
              if (ent == 3'd5) begin
                m[0] <= r[0]; m[1] <= r[1]; m[2] <= r[2];
                m[3] <= r[3]; m[4] <= r[4]; m[5] <= q_val;
                state <= S_DONE;
              end else begin
                ent <= ent + 3'd1;
                state <= S_DIV;
              end
            end
          end
        end
        S_DONE: begin
          res.out_00 <= m[0]; res.out_01 <= m[1]; res.out_02 <= m[2];
          res.out_10 <= m[3]; res.out_11 <= m[4]; res.out_12 <= m[5];
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_div_in_inv: assert property (@(posedge clk) disable iff (rst)
    dsts.busy |-> state == S_DIVW) else $error("divider running outside inverse");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed while waiting");
  a_map_keep: assert property (@(posedge clk) disable iff (rst)
    state == S_PROD && req.operation == aff2d_pkg::OP_MAP |=> $stable(m[0]))
    else $error("map changed matrix");

endmodule

### sv/aff2d_div.sv
// Restoring divider, one quotient bit per cycle: (mag << shift) / det.
// Depends on aff2d_pkg.
module aff2d_div (
  input  logic                clk,
  input  logic                rst,
  input  aff2d_pkg::div_cmd_t cmd,
  input  logic [63:0]         det,
  output aff2d_pkg::div_sts_t sts
);

  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [63:0]  quo;
  logic [6:0]   cnt;
  logic         busy;
  logic         done;
  logic         ovf;
  logic [127:0] wide;
  logic [64:0]  rem_sh;
  logic [64:0]  rem_sub;
  logic [63:0]  rem_left;

  assign wide     = {64'd0, cmd.mag} << cmd.shift;
  assign rem_sh   = {rem, lo[63]};
  assign rem_sub  = rem_sh - {1'b0, det};
  assign rem_left = det - rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        rem  <= wide[127:64];
        lo   <= wide[63:0];
        quo  <= '0;
        ovf  <= (wide[127:64] >= det);
        cnt  <= 7'd64;
        busy <= (wide[127:64] < det);
        done <= (wide[127:64] >= det);
      end else if (busy) begin
        if (!rem_sub[64]) begin
          rem <= rem_sub[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        lo  <= {lo[62:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy     = busy;
  assign sts.done     = done;
  assign sts.ovf      = ovf;
  assign sts.quo      = quo;
  assign sts.round_up = (rem >= rem_left);

  always_ff @(posedge clk) begin
    if (!rst && done) begin
      assert (!busy) else $error("divider done while busy");
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
  a_cnt_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 7'd0) else $error("divider busy with empty count");

endmodule
